// File: rtl/core/bru_pkg.sv
package bru_pkg;

    // Default source frame geometry
    localparam int BRU_SRC_WIDTH  = 320;
    localparam int BRU_SRC_HEIGHT = 240;

    // Field widths
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int COL_W     = 9;
    localparam int ROW_W     = 8;
    localparam int PIX_W     = 24;
    localparam int DST_W     = 12;
    localparam int ARGB_W    = 32;
    localparam int WGT_W     = 8;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     OUT_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0]     OUT_HEIGHT_RST = 13'd480;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // 16.16 mapping: half-pixel offset shift and integer position shift
    localparam int FRAC_SH  = 15;
    localparam int COORD_SH = 16;

    // Pixel lanes
    localparam logic [PIX_W-1:0] RB_LANES     = 24'hFF00FF;
    localparam logic [PIX_W-1:0] G_LANE       = 24'h00FF00;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CNT_W      = 3;

    // Item leaving the mapping pipeline
    typedef struct packed {
        logic             vld;
        logic             rd;
        logic             we;
        logic [WGT_W-1:0] wx;
        logic [WGT_W-1:0] wy;
        logic [PIX_W-1:0] wdata;
    } t_map_item;

    // Control aligned with frame store read data
    typedef struct packed {
        logic             issue;
        logic             ph0;
        logic             ph1;
        logic [WGT_W-1:0] wx;
        logic [WGT_W-1:0] wy;
    } t_fetch_ctl;

    // Two-lane blend of packed RGB pixels, weights 256-t and t
    function automatic logic [PIX_W-1:0] blend_px(input logic [PIX_W-1:0] p,
                                                  input logic [PIX_W-1:0] q,
                                                  input logic [WGT_W-1:0] t);
        logic [WGT_W:0] s;
        logic [31:0]    rb;
        logic [31:0]    g;
        s  = 9'd256 - {1'b0, t};
        rb = 32'(p & RB_LANES) * 32'(s) + 32'(q & RB_LANES) * 32'(t);
        g  = 32'(p & G_LANE) * 32'(s) + 32'(q & G_LANE) * 32'(t);
        return (rb[31:8] & RB_LANES) | (g[31:8] & G_LANE);
    endfunction

endpackage

// File: rtl/core/bru_in_if.sv
interface bru_in_if import bru_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [COL_W-1:0] src_col;
    logic [ROW_W-1:0] src_row;
    logic [PIX_W-1:0] src_rgb;
    logic [DST_W-1:0] dst_col;
    logic [DST_W-1:0] dst_row;

    modport source (output valid, cmd, src_col, src_row, src_rgb, dst_col, dst_row,
                    input ready);
    modport sink   (input valid, cmd, src_col, src_row, src_rgb, dst_col, dst_row,
                    output ready);
endinterface

// File: rtl/core/bru_out_if.sv
interface bru_out_if import bru_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ARGB_W-1:0] out_argb;

    modport source (output valid, out_argb, input ready);
    modport sink   (input valid, out_argb, output ready);
endinterface

// File: rtl/core/bilinear_rgb_upscaler_unit.sv
// Bilinear RGB upscaler. Write transactions (cmd 0) store one 24-bit pixel in a
// SRC_WIDTH x SRC_HEIGHT frame store and are taken one per cycle unless a read holds
// the pipeline; writes outside the frame are dropped. Read transactions (cmd 1)
// return one 0xFF-alpha ARGB pixel and hold the pipeline: with two read ports the
// frame store reads the four neighbors as the top row, then the bottom row. Both kinds
// travel in order through one pipeline of clog2(max(SRC_WIDTH, SRC_HEIGHT)) + 31
// stages (40 by default; a one-bit-per-stage divider for the center-aligned mapping
// by out_width/out_height), so a read always sees every earlier write. A read is
// issued only when the output queue has room. Frame entries are undefined until
// written; there is no clearing pass. The user must write out_width and out_height
// (reset 640 and 480, 0 acts as 1) only while no transaction is in flight; the block
// itself does not enforce it.
module bilinear_rgb_upscaler_unit import bru_pkg::*; #(
    parameter int SRC_WIDTH  = BRU_SRC_WIDTH,
    parameter int SRC_HEIGHT = BRU_SRC_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bru_in_if.sink               i_in,
    bru_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(SRC_WIDTH*SRC_HEIGHT);

    localparam logic PH_TOP = 1'b0;
    localparam logic PH_BOT = 1'b1;

    logic [CFG_W-1:0] r_out_width;
    logic [CFG_W-1:0] r_out_height;
    logic [CFG_W-1:0] div_x;
    logic [CFG_W-1:0] div_y;

    t_map_item        item;
    logic [AW-1:0]    addr_a;
    logic [AW-1:0]    addr_b;
    logic [AW-1:0]    addr_c;
    logic [AW-1:0]    addr_d;

    logic             r_phase;
    logic             n_phase;
    logic             take;
    logic             ram_we;
    logic             issue0;
    logic             issue1;
    logic             room;
    logic             r_ph0_d;
    logic             r_ph1_d;
    logic [WGT_W-1:0] r_wx;
    logic [WGT_W-1:0] r_wy;
    logic [AW-1:0]    raddr_a;
    logic [AW-1:0]    raddr_b;
    logic [PIX_W-1:0] rdata_a;
    logic [PIX_W-1:0] rdata_b;
    t_fetch_ctl       ctl;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= OUT_WIDTH_RST;
            r_out_height <= OUT_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data;
                CFG_OUT_HEIGHT: r_out_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Zero size acts as one
    assign div_x = (r_out_width == '0) ? CFG_W'(1) : r_out_width;
    assign div_y = (r_out_height == '0) ? CFG_W'(1) : r_out_height;

    bru_map #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_div_x  (div_x),
        .i_div_y  (div_y),
        .i_take   (take),
        .o_item   (item),
        .o_addr_a (addr_a),
        .o_addr_b (addr_b),
        .o_addr_c (addr_c),
        .o_addr_d (addr_d)
    );

    // Frame store sequencer: write a pixel, or read the top row then the bottom row
    always_comb begin
        n_phase = r_phase;
        take    = 1'b0;
        ram_we  = 1'b0;
        issue0  = 1'b0;
        issue1  = 1'b0;
        unique case (r_phase)
            PH_TOP: begin
                if (item.vld) begin
                    if (!item.rd) begin
                        take   = 1'b1;
                        ram_we = item.we;
                    end else if (room) begin
                        issue0  = 1'b1;
                        n_phase = PH_BOT;
                    end
                end
            end
            PH_BOT: begin
                issue1  = 1'b1;
                take    = 1'b1;
                n_phase = PH_TOP;
            end
            default: n_phase = PH_TOP;
        endcase
    end

    assign raddr_a = (r_phase == PH_BOT) ? addr_c : addr_a;
    assign raddr_b = (r_phase == PH_BOT) ? addr_d : addr_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOP;
            r_ph0_d <= 1'b0;
            r_ph1_d <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ph0_d <= issue0;
            r_ph1_d <= issue1;
        end
    end

    // Weights stay put until the next read starts
    always_ff @(posedge i_clk) begin
        if (issue0) begin
            r_wx <= item.wx;
            r_wy <= item.wy;
        end
    end

    bru_ram #(
        .WIDTH (PIX_W),
        .DEPTH (SRC_WIDTH*SRC_HEIGHT)
    ) u_frame (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (addr_a),
        .i_wdata   (item.wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_comb begin
        ctl.issue = issue0;
        ctl.ph0   = r_ph0_d;
        ctl.ph1   = r_ph1_d;
        ctl.wx    = r_wx;
        ctl.wy    = r_wy;
    end

    bru_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_rd_a  (rdata_a),
        .i_rd_b  (rdata_b),
        .o_out   (o_out),
        .o_room  (room)
    );

    // A top-row read is always followed by the bottom-row read
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue0 |=> issue1)
        else $error("bottom row read missing");

    // Second phase only runs on a held read transaction
    a_bot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BOT) |-> (item.vld && item.rd))
        else $error("second phase without a read");

    // No frame write while a read is being issued
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !(issue0 || issue1 || (r_phase == PH_BOT)))
        else $error("write overlaps a read");

endmodule

// File: rtl/core/bru_ram.sv
module bru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 76800
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: rtl/core/bru_map.sv
module bru_map import bru_pkg::*; #(
    parameter int SRC_WIDTH  = BRU_SRC_WIDTH,
    parameter int SRC_HEIGHT = BRU_SRC_HEIGHT
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    bru_in_if.sink                                  i_in,
    input  logic [CFG_W-1:0]                        i_div_x,
    input  logic [CFG_W-1:0]                        i_div_y,
    input  logic                                    i_take,
    output t_map_item                               o_item,
    output logic [$clog2(SRC_WIDTH*SRC_HEIGHT)-1:0] o_addr_a,
    output logic [$clog2(SRC_WIDTH*SRC_HEIGHT)-1:0] o_addr_b,
    output logic [$clog2(SRC_WIDTH*SRC_HEIGHT)-1:0] o_addr_c,
    output logic [$clog2(SRC_WIDTH*SRC_HEIGHT)-1:0] o_addr_d
);

    localparam int AW      = $clog2(SRC_WIDTH*SRC_HEIGHT);
    localparam int MAX_SRC = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    // (2*d+1) takes DST_W+1 bits; times the source size
    localparam int NA      = DST_W + 1 + $clog2(MAX_SRC);
    localparam int QW      = NA + FRAC_SH;
    localparam int CXW     = $clog2(SRC_WIDTH);
    localparam int CYW     = $clog2(SRC_HEIGHT);

    localparam logic [QW-1:0] HALF = QW'(1) << FRAC_SH;
    localparam logic [QW-1:0] TOPX = QW'(SRC_WIDTH - 1) << COORD_SH;
    localparam logic [QW-1:0] TOPY = QW'(SRC_HEIGHT - 1) << COORD_SH;

    logic adv;

    // Divider pipeline: stage 0 holds the dividend, stage k has k quotient bits
    logic             r_v   [0:QW];
    logic             r_rd  [0:QW];
    logic             r_we  [0:QW];
    logic [AW-1:0]    r_wa  [0:QW];
    logic [PIX_W-1:0] r_wd  [0:QW];
    logic [QW-1:0]    r_wkx [0:QW];
    logic [QW-1:0]    r_wky [0:QW];
    logic [CFG_W-1:0] r_rmx [0:QW];
    logic [CFG_W-1:0] r_rmy [0:QW];
    logic [QW-1:0]    n_wkx [1:QW];
    logic [QW-1:0]    n_wky [1:QW];
    logic [CFG_W-1:0] n_rmx [1:QW];
    logic [CFG_W-1:0] n_rmy [1:QW];

    // Mapping stage
    logic             r_mv;
    logic             r_mrd;
    logic             r_mwe;
    logic [AW-1:0]    r_mwa;
    logic [PIX_W-1:0] r_mwd;
    logic [CXW-1:0]   r_x0;
    logic [CXW-1:0]   r_x1;
    logic [CYW-1:0]   r_y0;
    logic [CYW-1:0]   r_y1;
    logic [WGT_W-1:0] r_mwx;
    logic [WGT_W-1:0] r_mwy;

    // Address stage
    logic             r_av;
    logic             r_ard;
    logic             r_awe;
    logic [PIX_W-1:0] r_awd;
    logic [AW-1:0]    r_aa;
    logic [AW-1:0]    r_ab;
    logic [AW-1:0]    r_ac;
    logic [AW-1:0]    r_ad;
    logic [WGT_W-1:0] r_awx;
    logic [WGT_W-1:0] r_awy;

    logic [QW-1:0]    qxm;
    logic [QW-1:0]    qxc;
    logic [QW-1:0]    qym;
    logic [QW-1:0]    qyc;
    logic [CXW-1:0]   x0;
    logic [CYW-1:0]   y0;
    logic [AW-1:0]    row0;
    logic [AW-1:0]    row1;

    // Whole pipeline moves together; it holds while the sequencer keeps the last item
    assign adv        = !r_av || i_take;
    assign i_in.ready = adv;

    // One restoring division step per stage, both axes side by side
    always_comb begin
        logic [CFG_W:0] trx;
        logic [CFG_W:0] try_;
        logic           gex;
        logic           gey;
        for (int k = 1; k <= QW; k++) begin
            trx  = {r_rmx[k-1], r_wkx[k-1][QW-1]};
            try_ = {r_rmy[k-1], r_wky[k-1][QW-1]};
            gex  = trx >= {1'b0, i_div_x};
            gey  = try_ >= {1'b0, i_div_y};
            n_rmx[k] = gex ? CFG_W'(trx - {1'b0, i_div_x}) : trx[CFG_W-1:0];
            n_rmy[k] = gey ? CFG_W'(try_ - {1'b0, i_div_y}) : try_[CFG_W-1:0];
            n_wkx[k] = {r_wkx[k-1][QW-2:0], gex};
            n_wky[k] = {r_wky[k-1][QW-2:0], gey};
        end
    end

    // Remove half-pixel offset, clamp to the source edge, split position and weight
    always_comb begin
        qxm = (r_wkx[QW] > HALF) ? r_wkx[QW] - HALF : '0;
        qym = (r_wky[QW] > HALF) ? r_wky[QW] - HALF : '0;
        qxc = (qxm > TOPX) ? TOPX : qxm;
        qyc = (qym > TOPY) ? TOPY : qym;
        x0  = qxc[COORD_SH +: CXW];
        y0  = qyc[COORD_SH +: CYW];
    end

    // Row bases for the address stage
    assign row0 = AW'(AW'(r_y0) * AW'(SRC_WIDTH));
    assign row1 = AW'(AW'(r_y1) * AW'(SRC_WIDTH));

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_v[k] <= 1'b0;
            end
            r_mv <= 1'b0;
            r_av <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_in.valid;
            for (int k = 1; k <= QW; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_mv <= r_v[QW];
            r_av <= r_mv;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // stage 0: decode, write address, dividends
            r_rd[0]  <= (i_in.cmd == CMD_READ);
            r_we[0]  <= (32'(i_in.src_col) < 32'(SRC_WIDTH)) &&
                        (32'(i_in.src_row) < 32'(SRC_HEIGHT));
            r_wa[0]  <= AW'(AW'(i_in.src_row) * AW'(SRC_WIDTH) + AW'(i_in.src_col));
            r_wd[0]  <= i_in.src_rgb;
            r_wkx[0] <= {NA'(NA'({i_in.dst_col, 1'b1}) * NA'(SRC_WIDTH)), {FRAC_SH{1'b0}}};
            r_wky[0] <= {NA'(NA'({i_in.dst_row, 1'b1}) * NA'(SRC_HEIGHT)), {FRAC_SH{1'b0}}};
            r_rmx[0] <= '0;
            r_rmy[0] <= '0;

            for (int k = 1; k <= QW; k++) begin
                r_rd[k]  <= r_rd[k-1];
                r_we[k]  <= r_we[k-1];
                r_wa[k]  <= r_wa[k-1];
                r_wd[k]  <= r_wd[k-1];
                r_wkx[k] <= n_wkx[k];
                r_wky[k] <= n_wky[k];
                r_rmx[k] <= n_rmx[k];
                r_rmy[k] <= n_rmy[k];
            end

            // mapping stage; the second neighbor repeats the first on the last column/row
            r_mrd <= r_rd[QW];
            r_mwe <= r_we[QW];
            r_mwa <= r_wa[QW];
            r_mwd <= r_wd[QW];
            r_x0  <= x0;
            r_y0  <= y0;
            r_x1  <= (x0 == CXW'(SRC_WIDTH - 1)) ? x0 : x0 + 1'b1;
            r_y1  <= (y0 == CYW'(SRC_HEIGHT - 1)) ? y0 : y0 + 1'b1;
            r_mwx <= qxc[COORD_SH-1 -: WGT_W];
            r_mwy <= qyc[COORD_SH-1 -: WGT_W];

            // address stage; a write keeps its own address in slot a
            r_ard <= r_mrd;
            r_awe <= r_mwe;
            r_awd <= r_mwd;
            r_aa  <= r_mrd ? row0 + AW'(r_x0) : r_mwa;
            r_ab  <= row0 + AW'(r_x1);
            r_ac  <= row1 + AW'(r_x0);
            r_ad  <= row1 + AW'(r_x1);
            r_awx <= r_mwx;
            r_awy <= r_mwy;
        end
    end

    always_comb begin
        o_item.vld   = r_av;
        o_item.rd    = r_ard;
        o_item.we    = r_awe;
        o_item.wx    = r_awx;
        o_item.wy    = r_awy;
        o_item.wdata = r_awd;
    end

    assign o_addr_a = r_aa;
    assign o_addr_b = r_ab;
    assign o_addr_c = r_ac;
    assign o_addr_d = r_ad;

endmodule

// File: rtl/core/bru_blend.sv
module bru_blend import bru_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_fetch_ctl       i_ctl,
    input  logic [PIX_W-1:0] i_rd_a,
    input  logic [PIX_W-1:0] i_rd_b,
    bru_out_if.source        o_out,
    output logic             o_room
);

    logic [PIX_W-1:0]   r_top;
    logic [PIX_W-1:0]   r_bot;
    logic [WGT_W-1:0]   r_wy;
    logic               r_hv;
    logic [ARGB_W-1:0]  r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_inflight;
    logic [PIX_W-1:0]   hblend;
    logic               push;
    logic               pop;

    // Shared horizontal blend on the two words the frame store returns
    assign hblend = blend_px(i_rd_a, i_rd_b, i_ctl.wx);

    assign push = r_hv;
    assign pop  = o_out.valid && o_out.ready;

    // Room counts queued results plus reads already issued
    assign o_room = ({1'b0, r_cnt} + {1'b0, r_inflight}) < (CNT_W+1)'(FIFO_DEPTH);

    // Top row blend, then bottom row blend, then vertical blend into the queue
    always_ff @(posedge i_clk) begin
        if (i_ctl.ph0) begin
            r_top <= hblend;
        end
        if (i_ctl.ph1) begin
            r_bot <= hblend;
            r_wy  <= i_ctl.wy;
        end
        if (push) begin
            r_fifo[r_wp] <= {ALPHA_OPAQUE, blend_px(r_top, r_bot, r_wy)};
        end
    end

    // Queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv       <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
            r_inflight <= '0;
        end else begin
            r_hv <= i_ctl.ph1;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt      <= r_cnt + CNT_W'(push) - CNT_W'(pop);
            r_inflight <= r_inflight + CNT_W'(i_ctl.issue) - CNT_W'(push);
        end
    end

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_argb = r_fifo[r_rp];

    // Reserved slots never exceed the queue
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt} + {1'b0, r_inflight}) <= (CNT_W+1)'(FIFO_DEPTH))
        else $error("output queue over-reserved");

    // A bottom-row word always follows a top-row word
    a_phase_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ph1 |-> $past(i_ctl.ph0))
        else $error("bottom row data without top row");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bru_pkg::*;

    localparam int SW            = BRU_SRC_WIDTH;
    localparam int SH            = BRU_SRC_HEIGHT;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 210;
    localparam int SETTLE_CYCLES = 150;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    // One input transaction plus an optional hand-typed expectation
    typedef struct {
        logic             cmd;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] rgb;
        logic [DST_W-1:0] dcol;
        logic [DST_W-1:0] drow;
        bit               has_exp;
        logic [31:0]      exp_argb;
    } t_px_req;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic             i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    bru_in_if  in_if();
    bru_out_if out_if();

    bilinear_rgb_upscaler_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow frame, shadow registers and expected pixel queue
    logic [PIX_W-1:0] frame_rgb [SW*SH];
    bit               pix_seen  [SW*SH];
    logic [CFG_W-1:0] cfg_w_cur;
    logic [CFG_W-1:0] cfg_h_cur;
    logic [31:0]      pending_argb [$];
    t_px_req          cur_item;

    int  fail_cnt      = 0;
    int  useful_items  = 0;
    int  tx_gap_pct    = 0;
    int  rx_stall_pct  = 0;
    int  rx_stall_left = 0;
    bit  calm_mode     = 1'b0;
    bit  hold_pending  = 1'b0;
    longint unsigned cyc_cnt = 0;

    int unsigned ph_w [N_PHASES] = '{1, 8191, 0, 4096, 320, 100, 2, 640};
    int unsigned ph_h [N_PHASES] = '{1, 8191, 0, 4096, 240, 100, 4096, 480};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Centre-aligned 16.16 source position, clamped to the last pixel
    function automatic longint unsigned map_pos(input int unsigned d, input int unsigned src,
                                                input int unsigned osz);
        longint unsigned num;
        longint unsigned q;
        longint unsigned half;
        longint unsigned lim;
        half = longint'(1) << FRAC_SH;
        lim  = longint'(src - 1) << COORD_SH;
        if (osz == 0)
            osz = 1;
        num = longint'(2 * d + 1) * longint'(src);
        num = num << FRAC_SH;
        q   = num / osz;
        q   = (q > half) ? q - half : 0;
        if (q > lim)
            q = lim;
        return q;
    endfunction

    // Four neighbors and the two weights of an output coordinate
    function automatic void locate(input logic [DST_W-1:0] dc, input logic [DST_W-1:0] dr,
                                   output int unsigned x0, output int unsigned x1,
                                   output int unsigned y0, output int unsigned y1,
                                   output logic [7:0] wx, output logic [7:0] wy);
        longint unsigned fx;
        longint unsigned fy;
        fx = map_pos(dc, SW, cfg_w_cur);
        fy = map_pos(dr, SH, cfg_h_cur);
        x0 = int'(fx >> COORD_SH);
        y0 = int'(fy >> COORD_SH);
        x1 = (x0 + 1 < SW) ? x0 + 1 : x0;
        y1 = (y0 + 1 < SH) ? y0 + 1 : y0;
        wx = 8'(fx >> 8);
        wy = 8'(fy >> 8);
    endfunction

    // Per-channel blend, weights 256-t and t
    function automatic logic [PIX_W-1:0] mix_px(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [7:0] t);
        logic [PIX_W-1:0] r;
        logic [16:0]      acc;
        for (int ch = 0; ch < 3; ch++) begin
            acc = 17'(a[ch*8 +: 8] * (256 - t) + b[ch*8 +: 8] * t);
            r[ch*8 +: 8] = acc[15:8];
        end
        return r;
    endfunction

    function automatic logic [31:0] predict_argb(input logic [DST_W-1:0] dc,
                                                 input logic [DST_W-1:0] dr);
        int unsigned x0, x1, y0, y1;
        logic [7:0] wx, wy;
        logic [PIX_W-1:0] top_px, bot_px;
        locate(dc, dr, x0, x1, y0, y1, wx, wy);
        top_px = mix_px(frame_rgb[y0*SW + x0], frame_rgb[y0*SW + x1], wx);
        bot_px = mix_px(frame_rgb[y1*SW + x0], frame_rgb[y1*SW + x1], wx);
        return {ALPHA_OPAQUE, mix_px(top_px, bot_px, wy)};
    endfunction

    function automatic t_px_req wr_row(input int unsigned col, input int unsigned row,
                                       input logic [PIX_W-1:0] rgb);
        t_px_req it;
        it.cmd      = CMD_WRITE;
        it.col      = COL_W'(col);
        it.row      = ROW_W'(row);
        it.rgb      = rgb;
        it.dcol     = DST_W'($urandom);
        it.drow     = DST_W'($urandom);
        it.has_exp  = 1'b0;
        it.exp_argb = '0;
        return it;
    endfunction

    function automatic t_px_req rd_row(input int unsigned dc, input int unsigned dr,
                                       input bit has_exp, input logic [31:0] exp_argb);
        t_px_req it;
        it.cmd      = CMD_READ;
        it.col      = COL_W'($urandom);
        it.row      = ROW_W'($urandom);
        it.rgb      = PIX_W'($urandom);
        it.dcol     = DST_W'(dc);
        it.drow     = DST_W'(dr);
        it.has_exp  = has_exp;
        it.exp_argb = exp_argb;
        return it;
    endfunction

    // Drive one transaction and hold it until accepted
    task automatic send_px(input t_px_req it);
        if (!calm_mode && $urandom_range(0, 99) < tx_gap_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        cur_item = it;
        in_if.valid   <= 1'b1;
        in_if.cmd     <= it.cmd;
        in_if.src_col <= it.col;
        in_if.src_row <= it.row;
        in_if.src_rgb <= it.rgb;
        in_if.dst_col <= it.dcol;
        in_if.dst_row <= it.drow;
        if (it.cmd == CMD_READ) begin
            useful_items++;
        end else if (it.col < SW && it.row < SH) begin
            pix_seen[it.row*SW + it.col] = 1'b1;
            useful_items++;
        end
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_argb.size() != 0);
    endtask

    task automatic write_cfg(input int unsigned w, input int unsigned h);
        wait_results_drained();
        // writes leave no result, so let the pipeline empty
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OUT_WIDTH;
        i_cfg_data <= CFG_W'(w);
        cfg_w_cur  = CFG_W'(w);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_OUT_HEIGHT;
        i_cfg_data <= CFG_W'(h);
        cfg_h_cur  = CFG_W'(h);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Make sure a frame entry holds data before any read touches it
    task automatic prep_pixel(input int unsigned x, input int unsigned y);
        if (!pix_seen[y*SW + x])
            send_px(wr_row(x, y, PIX_W'($urandom)));
    endtask

    task automatic issue_read();
        int unsigned x0, x1, y0, y1, lim_c, lim_r;
        logic [7:0] wx, wy;
        logic [DST_W-1:0] dc, dr;
        lim_c = (cfg_w_cur == 0) ? 1 : ((cfg_w_cur > 4096) ? 4096 : cfg_w_cur);
        lim_r = (cfg_h_cur == 0) ? 1 : ((cfg_h_cur > 4096) ? 4096 : cfg_h_cur);
        dc = ($urandom_range(0, 3) != 0) ? DST_W'($urandom_range(0, lim_c - 1))
                                         : DST_W'($urandom_range(0, 4095));
        dr = ($urandom_range(0, 3) != 0) ? DST_W'($urandom_range(0, lim_r - 1))
                                         : DST_W'($urandom_range(0, 4095));
        locate(dc, dr, x0, x1, y0, y1, wx, wy);
        prep_pixel(x0, y0);
        prep_pixel(x1, y0);
        prep_pixel(x0, y1);
        prep_pixel(x1, y1);
        send_px(rd_row(dc, dr, 1'b0, '0));
    endtask

    // Accepted transactions update the shadow frame; results are checked in order
    always @(posedge i_clk) begin : txn_mon
        logic [31:0] exp_v;
        if (i_rst_n === 1'b1) begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (pending_argb.size() == 0) begin
                    $error("out_argb: no result expected, actual %h", out_if.out_argb);
                    fail_cnt++;
                end else begin
                    exp_v = pending_argb.pop_front();
                    if (out_if.out_argb !== exp_v) begin
                        $error("out_argb: expected %h, actual %h", exp_v, out_if.out_argb);
                        fail_cnt++;
                    end
                end
            end
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
                if (in_if.cmd == CMD_WRITE) begin
                    if (in_if.src_col < SW && in_if.src_row < SH)
                        frame_rgb[in_if.src_row*SW + in_if.src_col] = in_if.src_rgb;
                end else begin
                    pending_argb.push_back(cur_item.has_exp ? cur_item.exp_argb
                                           : predict_argb(in_if.dst_col, in_if.dst_row));
                end
            end
        end
    end

    // Output back-pressure: random bursts, quiet stretches, one long hold
    always @(negedge i_clk) begin
        if (hold_pending) begin
            hold_pending  = 1'b0;
            rx_stall_left = LONG_HOLD;
        end else if (rx_stall_left == 0 && !calm_mode) begin
            if ($urandom_range(0, 199) == 0) begin
                case ($urandom_range(0, 2))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 5;
                    default: rx_stall_pct = 25;
                endcase
            end
            if ($urandom_range(0, 99) < rx_stall_pct)
                rx_stall_left = $urandom_range(1, 17);
        end
        if (rx_stall_left > 0) begin
            out_if.ready <= 1'b0;
            rx_stall_left--;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("bilinear_rgb_upscaler_unit regression: fail");
            $finish;
        end
    end

    initial begin
        t_px_req dir_tab [$];
        int unsigned phase_start;
        int          pick;
        bit          mid_drained;
        in_if.valid   = 1'b0;
        in_if.cmd     = CMD_WRITE;
        in_if.src_col = '0;
        in_if.src_row = '0;
        in_if.src_rgb = '0;
        in_if.dst_col = '0;
        in_if.dst_row = '0;
        out_if.ready  = 1'b1;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_OUT_WIDTH;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        cfg_w_cur     = OUT_WIDTH_RST;
        cfg_h_cur     = OUT_HEIGHT_RST;
        mid_drained   = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset geometry 640x480
        dir_tab.push_back(wr_row(0, 0, 24'hFF0000));
        dir_tab.push_back(wr_row(1, 0, 24'h00FF00));
        dir_tab.push_back(wr_row(0, 1, 24'h0000FF));
        dir_tab.push_back(wr_row(1, 1, 24'hFFFFFF));
        dir_tab.push_back(rd_row(0, 0, 1'b1, 32'hFFFF0000));      // top-left, zero weights
        dir_tab.push_back(wr_row(319, 239, 24'hFFFFFF));
        dir_tab.push_back(rd_row(4095, 4095, 1'b1, 32'hFFFFFFFF)); // clamped to last pixel
        dir_tab.push_back(wr_row(511, 255, 24'h000000));          // outside frame, dropped
        dir_tab.push_back(wr_row(320, 0, 24'hABCDEF));            // would alias (0,1)
        dir_tab.push_back(wr_row(0, 240, 24'hABCDEF));
        dir_tab.push_back(rd_row(0, 2, 1'b0, '0));                // uses (0,1)
        dir_tab.push_back(wr_row(318, 238, 24'h80FF01));
        dir_tab.push_back(wr_row(319, 238, 24'h017F80));
        dir_tab.push_back(wr_row(318, 239, 24'hFE0102));
        dir_tab.push_back(rd_row(637, 477, 1'b0, '0));
        dir_tab.push_back(wr_row(319, 0, 24'h5A5A5A));
        dir_tab.push_back(wr_row(319, 1, 24'hA5A5A5));
        dir_tab.push_back(rd_row(4095, 0, 1'b0, '0));             // last column, x1 = x0
        dir_tab.push_back(wr_row(0, 239, 24'h00FFFF));
        dir_tab.push_back(wr_row(1, 239, 24'hFFFF00));
        dir_tab.push_back(rd_row(0, 4095, 1'b0, '0));             // last row, y1 = y0
        dir_tab.push_back(wr_row(0, 0, 24'h000000));
        dir_tab.push_back(rd_row(0, 0, 1'b1, 32'hFF000000));      // sees the overwrite
        foreach (dir_tab[i])
            send_px(dir_tab[i]);

        // Random phases, one geometry each
        ph_w[5] = $urandom_range(1, 4096);
        ph_h[5] = $urandom_range(1, 4096);
        for (int p = 0; p < N_PHASES; p++) begin
            write_cfg(ph_w[p], ph_h[p]);
            calm_mode = (p == N_PHASES - 1);
            case ($urandom_range(0, 2))
                0: tx_gap_pct = 0;
                1: tx_gap_pct = 10;
                default: tx_gap_pct = 30;
            endcase
            if (p == 1) begin
                // sender keeps offering while the output is held off
                tx_gap_pct   = 0;
                hold_pending = 1'b1;
            end
            phase_start = useful_items;
            while (useful_items - phase_start < PHASE_ITEMS) begin
                if (p == 3 && !mid_drained
                        && useful_items - phase_start >= PHASE_ITEMS / 2) begin
                    wait_results_drained();
                    mid_drained = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    issue_read();
                end else if (pick < 85) begin
                    send_px(wr_row($urandom_range(0, SW - 1), $urandom_range(0, SH - 1),
                                   PIX_W'($urandom)));
                end else begin
                    // out-of-frame write, ignored by the block
                    if ($urandom_range(0, 1) == 0)
                        send_px(wr_row($urandom_range(SW, 511), $urandom_range(0, 255),
                                       PIX_W'($urandom)));
                    else
                        send_px(wr_row($urandom_range(0, 511), $urandom_range(SH, 255),
                                       PIX_W'($urandom)));
                end
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("bilinear_rgb_upscaler_unit regression: pass");
        end else begin
            $display("bilinear_rgb_upscaler_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/bru_pkg.sv
rtl/core/bru_in_if.sv
rtl/core/bru_out_if.sv
rtl/core/bru_ram.sv
rtl/core/bru_map.sv
rtl/core/bru_blend.sv
rtl/core/bilinear_rgb_upscaler_unit.sv
test/testbench.sv
